// ===== src/companding_bit_depth_quantizer_assert.svh =====
// ----------------------------------------------------------------------------
// companding bit depth quantizer assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef COMPANDING_BIT_DEPTH_QUANTIZER_ASSERT_SVH
`define COMPANDING_BIT_DEPTH_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define CBDQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cbdq assertion failed");
`define CBDQ_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("cbdq reset assertion failed");
`else
`define CBDQ_ASSERT(lbl, clk, rst_n, prop)
`define CBDQ_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== src/cbdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbdq_pkg
// shared types, constants and rom functions of the companding quantizer
// ----------------------------------------------------------------------------
package cbdq_pkg;

    localparam int FRAC_BITS = 23;
    localparam int MAX_DEPTH = 23;
    localparam int WORK_BITS = 30;
    localparam int MAG_W     = FRAC_BITS + 1;
    localparam int SMP_W     = 32;

    localparam logic [MAG_W-1:0] UNITY = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic             vld;
        logic             eob;
        logic             neg;
        logic [SMP_W-1:0] raw;
        logic [MAG_W-1:0] mag;
    } t_tag;

    typedef struct packed {
        logic [4:0] bits;
        logic       mu;
        logic       bypass;
    } t_cfg;

    typedef enum logic [0:0] {
        REG_QUANT_BITS = 1'b0,
        REG_MU_LAW_ON  = 1'b1
    } t_reg_idx;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'd1 << 62;
        x = n;
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // approximately 2^(2^-idx) in q.30
    function automatic logic [31:0] exp_rom(input int idx);
        logic [63:0] v;
        v = 64'd2 << WORK_BITS;
        for (int j = 1; j <= idx; j++) begin
            v = isqrt64(v << WORK_BITS);
        end
        return v[31:0];
    endfunction

endpackage

// ===== src/cbdq_stream_if.sv =====
// ----------------------------------------------------------------------------
// cbdq stream interfaces
// valid/ready channels for sample requests and quantized results
// ----------------------------------------------------------------------------
interface cbdq_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_in;
    logic        end_of_buffer;

    modport source (output valid, output sample_in, output end_of_buffer, input ready);
    modport sink   (input valid, input sample_in, input end_of_buffer, output ready);
endinterface

interface cbdq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_out;
    logic        end_of_buffer_out;

    modport source (output valid, output sample_out, output end_of_buffer_out, input ready);
    modport sink   (input valid, input sample_out, input end_of_buffer_out, output ready);
endinterface

// ===== src/cbdq_compress.sv =====
// ----------------------------------------------------------------------------
// cbdq_compress
// mu-law compression of the magnitude when mu is set: log2 by repeated
// squaring, one squaring per pipeline stage
// ----------------------------------------------------------------------------
module cbdq_compress (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  cbdq_pkg::t_cfg i_cfg,
    input  cbdq_pkg::t_tag i_tag,
    output cbdq_pkg::t_tag o_tag
);
    import cbdq_pkg::*;

    localparam int ZW = WORK_BITS + 1;
    localparam int SQ = FRAC_BITS;
    localparam int UW = FRAC_BITS + 9;
    localparam int XW = UW + WORK_BITS - FRAC_BITS;
    localparam int YW = FRAC_BITS + 5;

    logic [UW-1:0]        w_u;
    logic [3:0]           w_e;
    logic [XW-1:0]        w_ush;
    logic [YW-1:0]        w_y;
    t_tag                 n_out;

    logic [ZW-1:0]        r_z    [SQ+1];
    logic [FRAC_BITS-1:0] r_frac [SQ+1];
    logic [3:0]           r_e    [SQ+1];
    t_tag                 r_tag  [SQ+1];
    t_tag                 r_out;

    always_comb begin
        w_u = UW'(UNITY) + (UW'(i_tag.mag) << 8) - UW'(i_tag.mag);
        w_e = '0;
        for (int j = 1; j <= 8; j++) begin
            if (w_u >= (UW'(UNITY) << j)) begin
                w_e = 4'(j);
            end
        end
        w_ush = {w_u, {(WORK_BITS-FRAC_BITS){1'b0}}} >> w_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0].vld <= 1'b0;
        end else if (i_en) begin
            r_z[0]    <= w_ush[ZW-1:0];
            r_e[0]    <= w_e;
            r_frac[0] <= '0;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar j = 1; j <= SQ; j++) begin : g_sq
        logic [2*ZW-1:0] w_sq;
        logic [ZW:0]     w_top;

        assign w_sq  = r_z[j-1] * r_z[j-1];
        assign w_top = w_sq[2*ZW-1:WORK_BITS];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[j].vld <= 1'b0;
            end else if (i_en) begin
                r_z[j]    <= w_top[ZW] ? w_top[ZW:1] : w_top[ZW-1:0];
                r_frac[j] <= {r_frac[j-1][FRAC_BITS-2:0], w_top[ZW]};
                r_e[j]    <= r_e[j-1];
                r_tag[j]  <= r_tag[j-1];
            end
        end
    end

    always_comb begin
        w_y   = ({1'b0, r_e[SQ], r_frac[SQ]} + YW'(4)) >> 3;
        n_out = r_tag[SQ];
        if (i_cfg.mu) begin
            n_out.mag = w_y[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_tag = r_out;

endmodule

// ===== src/cbdq_quant.sv =====
// ----------------------------------------------------------------------------
// cbdq_quant
// round half-up to the level index, clamp to the code range, scale back
// ----------------------------------------------------------------------------
module cbdq_quant (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  cbdq_pkg::t_cfg i_cfg,
    input  cbdq_pkg::t_tag i_tag,
    output cbdq_pkg::t_tag o_tag
);
    import cbdq_pkg::*;

    localparam int IW = MAG_W + 1;
    localparam int PW = 2 * MAG_W;

    logic signed [IW-1:0]    w_v;
    logic        [4:0]       w_sh;
    logic signed [PW-1:0]    w_prod;
    logic signed [PW-1:0]    w_rnd;
    logic signed [IW-1:0]    w_hi;
    logic signed [IW-1:0]    w_lo;
    logic signed [IW-1:0]    w_idx;
    logic signed [SMP_W-1:0] w_q;
    t_tag                    n_out;

    logic signed [IW-1:0]    r_idx;
    t_tag                    r_tag;
    t_tag                    r_out;

    always_comb begin
        w_v    = i_tag.neg ? -$signed({1'b0, i_tag.mag}) : $signed({1'b0, i_tag.mag});
        w_sh   = i_cfg.bits - 5'd1;
        w_prod = PW'(w_v) <<< w_sh;
        w_rnd  = (w_prod + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_idx <= w_rnd[IW-1:0];
            r_tag <= i_tag;
        end
    end

    always_comb begin
        w_hi = $signed(IW'(1) << (i_cfg.bits - 5'd1)) - IW'(1);
        w_lo = -$signed(IW'(1) << (i_cfg.bits - 5'd1));
        priority if (r_idx > w_hi) begin
            w_idx = w_hi;
        end else if (r_idx < w_lo) begin
            w_idx = w_lo;
        end else begin
            w_idx = r_idx;
        end
        w_q       = SMP_W'(w_idx) <<< (5'(FRAC_BITS + 1) - i_cfg.bits);
        n_out     = r_tag;
        n_out.neg = w_q[SMP_W-1];
        n_out.mag = w_q[SMP_W-1] ? MAG_W'(-w_q) : MAG_W'(w_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_tag = r_out;

endmodule

// ===== src/cbdq_expand.sv =====
// ----------------------------------------------------------------------------
// cbdq_expand
// mu-law expansion: 2^x as a product of rom factors, one per stage, then
// division by a constant and final output selection
// ----------------------------------------------------------------------------
module cbdq_expand (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  cbdq_pkg::t_cfg              i_cfg,
    input  cbdq_pkg::t_tag              i_tag,
    output logic                        o_vld,
    output logic                        o_eob,
    output logic [cbdq_pkg::SMP_W-1:0]  o_sample
);
    import cbdq_pkg::*;

    localparam int NS  = FRAC_BITS - 3;
    localparam int PW  = WORK_BITS + 1;
    localparam int WW  = PW + 8;
    localparam int NW  = WW + 1;
    localparam int SH  = WORK_BITS - FRAC_BITS;
    localparam int N2W = NW - SH;
    localparam int SW  = N2W + 1;
    localparam int QW  = SW - 8;
    localparam logic [NW-1:0] HALF_D = NW'(255) << (SH - 1);

    logic [WW-1:0]  w_w;
    logic [NW-1:0]  w_n;
    logic [N2W-1:0] w_n2;
    logic [SW-1:0]  w_s;
    logic [SW-1:0]  w_r;
    logic [QW-1:0]  w_x;
    logic [MAG_W-1:0]        w_mag;
    logic [SMP_W-1:0]        w_res;

    logic [PW-1:0]  r_p   [NS+1];
    t_tag           r_tag [NS+1];
    logic [N2W-1:0] r_n2;
    logic [QW-1:0]  r_q0;
    t_tag           r_dtag;
    logic           r_vld;
    logic           r_eob;
    logic [SMP_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0].vld <= 1'b0;
        end else if (i_en) begin
            r_p[0]   <= PW'(1) << WORK_BITS;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar j = 1; j <= NS; j++) begin : g_mul
        localparam logic [31:0] ROM = exp_rom(j);
        logic [PW+31:0] w_m;

        assign w_m = r_p[j-1] * ROM;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[j].vld <= 1'b0;
            end else if (i_en) begin
                r_p[j]   <= r_tag[j-1].mag[NS-j] ? w_m[WORK_BITS+PW-1:WORK_BITS] : r_p[j-1];
                r_tag[j] <= r_tag[j-1];
            end
        end
    end

    // divide by 255 via series of shifts, corrected later
    always_comb begin
        w_w  = WW'(r_p[NS]) << r_tag[NS].mag[MAG_W-1:NS];
        w_n  = NW'(w_w) - (NW'(1) << WORK_BITS) + HALF_D;
        w_n2 = w_n[NW-1:SH];
        w_s  = SW'(w_n2) + SW'(w_n2 >> 8) + SW'(w_n2 >> 16) + SW'(w_n2 >> 24)
             + SW'(w_n2 >> 32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dtag.vld <= 1'b0;
        end else if (i_en) begin
            r_n2   <= w_n2;
            r_q0   <= w_s[SW-1:8];
            r_dtag <= r_tag[NS];
        end
    end

    always_comb begin
        w_r = SW'(r_n2) - ((SW'(r_q0) << 8) - SW'(r_q0));
        w_x = (w_r >= SW'(255)) ? r_q0 + QW'(1) : r_q0;
        if (!i_cfg.mu) begin
            w_mag = r_dtag.mag;
        end else if (w_x > QW'(UNITY)) begin
            w_mag = UNITY;
        end else begin
            w_mag = w_x[MAG_W-1:0];
        end
        w_res = r_dtag.neg ? -SMP_W'(w_mag) : SMP_W'(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld    <= r_dtag.vld;
            r_eob    <= r_dtag.eob;
            r_sample <= i_cfg.bypass ? r_dtag.raw : w_res;
        end
    end

    assign o_vld    = r_vld;
    assign o_eob    = r_eob;
    assign o_sample = r_sample;

endmodule

// ===== src/companding_bit_depth_quantizer.sv =====
// ----------------------------------------------------------------------------
// companding_bit_depth_quantizer
// clamps, optionally mu-law compresses, quantizes to a pcm grid and expands
// q8.23 samples; apb registers select bit depth and companding
// ----------------------------------------------------------------------------
// channel   dir   handshake      payload
// i_smp     in    valid/ready    sample_in, end_of_buffer
// o_smp     out   valid/ready    sample_out, end_of_buffer_out
// apb       in    psel/penable   quant_bits, mu_law_on
//
// one request per cycle unless stalled; samples pass clamp, 23 squaring
// stages, 2 quantizer stages, 20 rom multiply stages and the divider
// the whole pipeline advances together; it holds while a result waits
// reset clears the registers to bypass and empties the pipeline
// ----------------------------------------------------------------------------
`include "companding_bit_depth_quantizer_assert.svh"

module companding_bit_depth_quantizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbdq_in_if.sink     i_smp,
    cbdq_out_if.source  o_smp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbdq_pkg::*;

    localparam logic signed [SMP_W-1:0] S_UNITY = SMP_W'(UNITY);

    logic [4:0]  r_quant_bits;
    logic        r_mu_law_on;
    t_cfg        w_cfg;
    t_reg_idx    w_idx;
    logic        w_en;
    logic        w_wr;

    logic signed [SMP_W-1:0] w_s;
    logic signed [SMP_W-1:0] w_cl;
    t_tag        n_in;
    t_tag        r_in;
    t_tag        w_ctag;
    t_tag        w_qtag;
    logic        w_ovld;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_bits <= '0;
            r_mu_law_on  <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_QUANT_BITS: r_quant_bits <= pwdata[4:0];
                REG_MU_LAW_ON:  r_mu_law_on  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_QUANT_BITS: prdata = {27'd0, r_quant_bits};
            REG_MU_LAW_ON:  prdata = {31'd0, r_mu_law_on};
            default:        prdata = '0;
        endcase
    end

    assign w_cfg.bits   = r_quant_bits;
    assign w_cfg.mu     = r_mu_law_on;
    assign w_cfg.bypass = (r_quant_bits == 5'd0) || (r_quant_bits > 5'(MAX_DEPTH));

    assign w_en        = !w_ovld || o_smp.ready;
    assign i_smp.ready = w_en;

    // clamp to unity and split sign
    always_comb begin
        w_s = $signed(i_smp.sample_in);
        priority if (w_s > S_UNITY) begin
            w_cl = S_UNITY;
        end else if (w_s < -S_UNITY) begin
            w_cl = -S_UNITY;
        end else begin
            w_cl = w_s;
        end
        n_in.vld = i_smp.valid;
        n_in.eob = i_smp.end_of_buffer;
        n_in.raw = i_smp.sample_in;
        n_in.neg = w_cl[SMP_W-1];
        n_in.mag = w_cl[SMP_W-1] ? MAG_W'(-w_cl) : MAG_W'(w_cl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else if (w_en) begin
            r_in <= n_in;
        end
    end

    cbdq_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_tag   (r_in),
        .o_tag   (w_ctag)
    );

    cbdq_quant u_quant (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_tag   (w_ctag),
        .o_tag   (w_qtag)
    );

    cbdq_expand u_expand (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_cfg    (w_cfg),
        .i_tag    (w_qtag),
        .o_vld    (w_ovld),
        .o_eob    (o_smp.end_of_buffer_out),
        .o_sample (o_smp.sample_out)
    );

    assign o_smp.valid = w_ovld;

    `CBDQ_ASSERT(a_in_enters, i_clk, i_rst_n, i_smp.valid && i_smp.ready |=> r_in.vld)
    `CBDQ_ASSERT(a_range, i_clk, i_rst_n, o_smp.valid && !w_cfg.bypass |-> $signed(o_smp.sample_out) <= S_UNITY && $signed(o_smp.sample_out) >= -S_UNITY)
    `CBDQ_ASSERT(a_one_bit, i_clk, i_rst_n, o_smp.valid && r_quant_bits == 5'd1 |-> o_smp.sample_out == 32'd0 || $signed(o_smp.sample_out) == -S_UNITY)
    `CBDQ_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_smp.valid)

endmodule
